// ===== hw/rtl/gclf_pkg.sv =====
// Package: widths, command codes, item types and sequencer states of the gcd/lcm/fraction unit
`timescale 1ns / 1ps

package gclf_pkg;

	localparam int DATA_W = 64;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_GCD      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SIMPLIFY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LCM      = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
	} gclf_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_main;
		logic [DATA_W-1:0] result_denominator;
		logic              overflow;
		logic              bad_operand;
	} gclf_rsp_t;

	// request to the shared adder/subtractor
	typedef struct packed {
		logic              sub;
		logic [DATA_W-1:0] op_a;
		logic [DATA_W-1:0] op_b;
	} gclf_alu_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_SHIFT,
		ST_DIV,
		ST_MUL
	} gclf_state_t;

endpackage

// ===== hw/rtl/gclf_alu.sv =====
// Module: shared 64-bit adder/subtractor with carry/borrow out
`timescale 1ns / 1ps

module gclf_alu import gclf_pkg::*; (
	input  gclf_alu_req_t     req,
	output logic [DATA_W:0]   res
);

	// bit DATA_W is the carry on add, the borrow (op_a < op_b) on subtract
	always_comb begin
		if (req.sub) begin
			res = {1'b0, req.op_a} - {1'b0, req.op_b};
		end else begin
			res = {1'b0, req.op_a} + {1'b0, req.op_b};
		end
	end

endmodule

// ===== hw/rtl/gcd_lcm_fraction_unit_top.sv =====
// Top level: sequencer around one shared adder for gcd, lcm and fraction reduction
`timescale 1ns / 1ps
// Timing: an item with a zero operand or an unused command strobes done in the cycle after
//   the accepting edge. Otherwise the steps run in order: binary gcd, then restoring the
//   common factors of two and closing the gcd, then for simplify and lcm division (two
//   divisions for simplify), then shift-add multiply for lcm; done is registered from the
//   last step.
// Throughput: one item at a time, one adder step a cycle; busy drops as done rises.
// Reset: arst_n clears the sequencer and done asynchronously; the receiver cannot stall.

module gcd_lcm_fraction_unit_top import gclf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gclf_req_t request,
	output logic      busy,
	output logic      done,
	output gclf_rsp_t result
);

	gclf_state_t state_q, state_d;

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] a_q, b_q;     // operands; a_q later holds the reduced numerator
	logic [DATA_W-1:0] x_q;          // gcd working value, then the divisor
	logic [DATA_W-1:0] y_q;          // gcd working value, dividend/quotient, product low half
	logic [DATA_W-1:0] rem_q;        // division remainder, product high half
	logic [CNT_W-1:0]  k_q;          // common factors of two stripped from both operands
	logic [CNT_W-1:0]  cnt_q;        // bit counter for division and multiply
	logic              div2_q;       // simplify: second division (denominator) running
	logic              done_q;
	gclf_rsp_t         result_q;

	gclf_alu_req_t     alu_req;
	logic [DATA_W:0]   alu_res;

	logic              za, zb;
	logic              both_odd, gcd_eq, gcd_lt;
	logic              last, take;
	logic [DATA_W-1:0] quot, mul_hi, mul_lo;
	logic              fin;
	gclf_rsp_t         fin_res;

	gclf_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign za       = (request.operand_a == '0);
	assign zb       = (request.operand_b == '0);
	assign both_odd = x_q[0] & y_q[0];
	assign gcd_eq   = (alu_res == '0);
	assign gcd_lt   = alu_res[DATA_W];
	assign last     = &cnt_q;
	// restoring division: a set top bit of the remainder means the shifted value beats any divisor
	assign take     = rem_q[DATA_W-1] | ~alu_res[DATA_W];
	assign quot     = {y_q[DATA_W-2:0], take};
	assign mul_hi   = alu_res[DATA_W:1];
	assign mul_lo   = {alu_res[0], y_q[DATA_W-1:1]};

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (request.command)
						CMD_GCD, CMD_LCM, CMD_SIMPLIFY: begin
							if (!za && !zb) state_d = ST_GCD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_GCD: begin
				if (both_odd && gcd_eq) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (k_q == '0) begin
					state_d = (cmd_q == CMD_GCD) ? ST_IDLE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (last) begin
					if (cmd_q == CMD_LCM) begin
						state_d = ST_MUL;
					end else if (div2_q) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MUL: begin
				if (last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: operands of the shared adder
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_GCD: begin
				alu_req.sub  = 1'b1;
				alu_req.op_a = x_q;
				alu_req.op_b = y_q;
			end
			ST_DIV: begin
				alu_req.sub  = 1'b1;
				alu_req.op_a = {rem_q[DATA_W-2:0], y_q[DATA_W-1]};
				alu_req.op_b = x_q;
			end
			ST_MUL: begin
				alu_req.sub  = 1'b0;
				alu_req.op_a = rem_q;
				alu_req.op_b = y_q[0] ? b_q : '0;
			end
			default: alu_req = '0;
		endcase
	end

	// Outputs: finishing an item and its result
	always_comb begin
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (request.command)
						CMD_GCD, CMD_LCM: begin
							if (za || zb) begin
								fin = 1'b1;
								if (!za) begin
									fin_res.result_main = request.operand_a;
								end else if (!zb) begin
									fin_res.result_main = request.operand_b;
								end else begin
									fin_res.result_main = DATA_W'(1);
								end
							end
						end
						CMD_SIMPLIFY: begin
							if (za) begin
								fin                        = 1'b1;
								fin_res.result_denominator = DATA_W'(1);
								fin_res.bad_operand        = zb;
							end else if (zb) begin
								fin                 = 1'b1;
								fin_res.result_main = DATA_W'(1);
								fin_res.bad_operand = 1'b1;
							end
						end
						default: fin = 1'b1;   // unused command: all-zero result
					endcase
				end
			end
			ST_SHIFT: begin
				if (k_q == '0 && cmd_q == CMD_GCD) begin
					fin                 = 1'b1;
					fin_res.result_main = x_q;
				end
			end
			ST_DIV: begin
				if (last && cmd_q == CMD_SIMPLIFY && div2_q) begin
					fin                        = 1'b1;
					fin_res.result_main        = a_q;
					fin_res.result_denominator = quot;
				end
			end
			ST_MUL: begin
				if (last) begin
					fin                 = 1'b1;
					fin_res.result_main = mul_lo;
					fin_res.overflow    = |mul_hi;
				end
			end
			default: fin = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (fin) result_q <= fin_res;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= request.command;
					a_q   <= request.operand_a;
					b_q   <= request.operand_b;
					x_q   <= request.operand_a;
					y_q   <= request.operand_b;
					k_q   <= '0;
				end
			end
			ST_GCD: begin
				// binary gcd: drop twos, or subtract the smaller odd value from the larger
				if (both_odd) begin
					if (gcd_lt) begin
						x_q <= y_q;
						y_q <= x_q;
					end else if (!gcd_eq) begin
						x_q <= {1'b0, alu_res[DATA_W-1:1]};
					end
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= {1'b0, x_q[DATA_W-1:1]};
					y_q <= {1'b0, y_q[DATA_W-1:1]};
					k_q <= k_q + CNT_W'(1);
				end else if (!x_q[0]) begin
					x_q <= {1'b0, x_q[DATA_W-1:1]};
				end else begin
					y_q <= {1'b0, y_q[DATA_W-1:1]};
				end
			end
			ST_SHIFT: begin
				// restore the common factors of two, then load the first dividend
				if (k_q != '0) begin
					x_q <= {x_q[DATA_W-2:0], 1'b0};
					k_q <= k_q - CNT_W'(1);
				end else begin
					y_q    <= a_q;
					rem_q  <= '0;
					cnt_q  <= '0;
					div2_q <= 1'b0;
				end
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last && cmd_q == CMD_LCM) begin
					y_q   <= quot;
					rem_q <= '0;        // product high half
				end else if (last && !div2_q) begin
					a_q    <= quot;     // hold the reduced numerator
					y_q    <= b_q;
					rem_q  <= '0;
					div2_q <= 1'b1;
				end else begin
					rem_q <= take ? alu_res[DATA_W-1:0] : {rem_q[DATA_W-2:0], y_q[DATA_W-1]};
					y_q   <= quot;
				end
			end
			ST_MUL: begin
				rem_q <= mul_hi;
				y_q   <= mul_lo;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("done strobe outside idle");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GCD |-> (x_q != '0) && (y_q != '0))
		else $error("gcd working value reached zero");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < x_q)
		else $error("division remainder not below divisor");

	a_mul_lcm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cmd_q == CMD_LCM)
		else $error("multiply entered for a command other than lcm");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && cmd_q != CMD_SIMPLIFY |->
			result_q.result_denominator == '0 && !result_q.bad_operand)
		else $error("simplify-only fields set for another command");

endmodule
